### rtl/block_epistasis_xor_transform_assert.svh
// Assertion macros used by the checker file.
// They expect signals named clock and reset in the enclosing scope.
`ifndef BLOCK_EPISTASIS_XOR_TRANSFORM_ASSERT_SVH
`define BLOCK_EPISTASIS_XOR_TRANSFORM_ASSERT_SVH

// antecedent this cycle implies consequent next cycle, off while in reset
`define EBX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold the cycle after reset is sampled high
`define EBX_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

### rtl/ebx_pkg.sv
package ebx_pkg;

   localparam int DATA_W   = 64;
   localparam int MAX_BITS = 64;
   localparam int POS_W    = $clog2(DATA_W);
   localparam int LEN_W    = POS_W + 1;
   localparam int CFG_W    = 7;
   localparam int ADDR_W   = 5;
   localparam int IDX_W    = 2;

   localparam logic [IDX_W-1:0] REG_BLK_LEN       = 2'd0;
   localparam logic [IDX_W-1:0] REG_VECTOR_LENGTH = 2'd1;
   localparam logic [IDX_W-1:0] REG_FLIP_MASK     = 2'd2;

   // per-position decode, built by the sweep after every register write
   typedef struct packed {
      logic              act;       // position below the vector length
      logic              excl_on;   // not the last position of its block
      logic [POS_W-1:0]  start;     // first position of the block
      logic [LEN_W-1:0]  stop;      // one past the last position of the block
      logic [POS_W-1:0]  excl_pos;  // bit left out of the block parity
   } pos_ctl_type;

   typedef struct packed {
      logic [CFG_W-1:0]  blk_len;
      logic [CFG_W-1:0]  vector_length;
      logic [DATA_W-1:0] flip_mask;
      logic              update;    // register write this cycle
   } cfg_type;

endpackage

### rtl/ebx_csr.sv
module ebx_csr import ebx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [CFG_W-1:0]  blk_len_ff, blk_len_in;
   logic [CFG_W-1:0]  vector_length_ff, vector_length_in;
   logic [DATA_W-1:0] flip_mask_ff, flip_mask_in;
   logic              wr_en;
   logic [IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[ADDR_W-1:ADDR_W-IDX_W];

   always_comb begin
      blk_len_in       = blk_len_ff;
      vector_length_in = vector_length_ff;
      flip_mask_in     = flip_mask_ff;
      if (wr_en) begin
         case (idx)
            REG_BLK_LEN:       blk_len_in       = csr_pwdata[CFG_W-1:0];
            REG_VECTOR_LENGTH: vector_length_in = csr_pwdata[CFG_W-1:0];
            REG_FLIP_MASK:     flip_mask_in     = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_BLK_LEN:       csr_prdata = {{(DATA_W-CFG_W){1'b0}}, blk_len_ff};
         REG_VECTOR_LENGTH: csr_prdata = {{(DATA_W-CFG_W){1'b0}}, vector_length_ff};
         REG_FLIP_MASK:     csr_prdata = flip_mask_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_len_ff       <= CFG_W'(1);
         vector_length_ff <= CFG_W'(MAX_BITS);
         flip_mask_ff     <= '0;
      end else begin
         blk_len_ff       <= blk_len_in;
         vector_length_ff <= vector_length_in;
         flip_mask_ff     <= flip_mask_in;
      end
   end

   assign cfg.blk_len       = blk_len_ff;
   assign cfg.vector_length = vector_length_ff;
   assign cfg.flip_mask     = flip_mask_ff;
   assign cfg.update        = wr_en;

endmodule

### rtl/ebx_decode.sv
module ebx_decode import ebx_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   output logic                     busy,
   output pos_ctl_type [DATA_W-1:0] ctl
);

   logic                     busy_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [LEN_W-1:0]         head_ff, head_in;
   logic [LEN_W-1:0]         off_ff, off_in;
   pos_ctl_type [DATA_W-1:0] ctl_ff;

   logic [LEN_W-1:0] vlen, bsize, rem, len, kk;
   logic             in_range, last;
   pos_ctl_type      entry;

   always_comb begin
      vlen = (LEN_W'(cfg.vector_length) > LEN_W'(MAX_BITS)) ?
             LEN_W'(MAX_BITS) : LEN_W'(cfg.vector_length);
      bsize = (cfg.blk_len == '0 || LEN_W'(cfg.blk_len) > vlen) ?
              vlen : LEN_W'(cfg.blk_len);
      in_range = {1'b0, pos_ff} < vlen;
      rem  = vlen - head_ff;
      len  = (rem > bsize) ? bsize : rem;
      last = (off_ff + LEN_W'(1)) == len;
      // distance from the block end, counted mod 4, picks the dropped bit
      kk   = len - off_ff - LEN_W'(2);

      entry.act      = in_range;
      entry.excl_on  = ~last;
      entry.start    = head_ff[POS_W-1:0];
      entry.stop     = head_ff + len;
      entry.excl_pos = POS_W'(head_ff + len - LEN_W'(1) - {{(LEN_W-2){1'b0}}, kk[1:0]});

      head_in = head_ff;
      off_in  = off_ff;
      if (in_range) begin
         if (last) begin
            head_in = head_ff + len;
            off_in  = '0;
         end else begin
            off_in  = off_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.update) begin
         busy_ff <= 1'b1;
         pos_ff  <= '0;
         head_ff <= '0;
         off_ff  <= '0;
      end else if (busy_ff) begin
         if (pos_ff == POS_W'(DATA_W - 1)) begin
            busy_ff <= 1'b0;
         end
         pos_ff  <= pos_ff + POS_W'(1);
         head_ff <= head_in;
         off_ff  <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         ctl_ff[pos_ff] <= entry;
      end
   end

   assign busy = busy_ff;
   assign ctl  = ctl_ff;

endmodule

### rtl/ebx_core.sv
module ebx_core import ebx_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     busy,
   input  pos_ctl_type [DATA_W-1:0] ctl,
   input  logic [DATA_W-1:0]        flip_mask,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_W-1:0]        req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata
);

   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_take, req_fire;
   logic [DATA_W:0]   pref;
   logic [DATA_W-1:0] result;

   assign out_take   = ~out_valid_ff | rsp_tready;
   assign req_tready = ~busy & (~in_valid_ff | out_take);
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (out_take) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_take ? in_valid_ff : out_valid_ff;
   end

   // pref[j] is the parity of bits below j; a block parity is a pair of them
   always_comb begin
      logic [DATA_W:0] m;
      for (int j = 0; j <= DATA_W; j++) begin
         m       = ((DATA_W+1)'(1) << j) - (DATA_W+1)'(1);
         pref[j] = ^(in_data_ff & m[DATA_W-1:0]);
      end
   end

   always_comb begin
      for (int i = 0; i < DATA_W; i++) begin
         result[i] = ctl[i].act &
                     (pref[ctl[i].stop] ^ pref[{1'b0, ctl[i].start}] ^
                      (ctl[i].excl_on & in_data_ff[ctl[i].excl_pos]) ^ flip_mask[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata;
      end
      if (out_take) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### rtl/block_epistasis_xor_transform.sv
// Epistasis XOR transform of a 64-bit vector.
// req_* stream: one vector per transaction, tdata = in_bits.
// rsp_* stream: one result per transaction, tdata = out_bits (bits at or
//   above the vector length read as zero).
// csr_* port: block length at 0x00, vector length at 0x08, flip mask at 0x10.
// Path: a vector accepted on req is registered in the input register; its
//   result is registered in the result register, which drives rsp.
// Throughput: one vector per cycle when rsp and the decode sweep do not stall;
//   block positions are decoded once into a per-bit table, so each vector needs
//   only a prefix-parity network. After reset and each register write a decode
//   sweep fills it, one bit position a cycle; req_tready stays low meanwhile.
// Reset clears both pipeline stages and loads block length 1, vector length 64
//   and flip mask 0.
// When rsp_tready is low the result register holds, the input register
//   takes one more vector, and then req_tready drops until rsp drains.
module block_epistasis_xor_transform import ebx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [63:0] in_bits
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [63:0] out_bits
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type                  cfg;
   logic                     busy;
   pos_ctl_type [DATA_W-1:0] ctl;

   ebx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ebx_decode u_decode (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .busy  (busy),
      .ctl   (ctl)
   );

   ebx_core u_core (
      .clock      (clock),
      .reset      (reset),
      .busy       (busy),
      .ctl        (ctl),
      .flip_mask  (cfg.flip_mask),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/ebx_checker.sv
`include "block_epistasis_xor_transform_assert.svh"

module ebx_checker import ebx_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic              csr_pready
);

   logic csr_write;
   logic rsp_stall;

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign rsp_stall = rsp_tvalid & ~rsp_tready;

   // a stalled result must stay offered, unchanged
   `EBX_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "rsp moved")
   // a register write restarts the decode sweep, so no vector is taken next cycle
   `EBX_ASSERT_NEXT(a_cfg_blocks, csr_write, !req_tready, "req ready right after csr write")
   `EBX_ASSERT_AFTER_RESET(a_rst_ready, !req_tready, "req ready right after reset")
   `EBX_ASSERT_AFTER_RESET(a_rst_rsp, !rsp_tvalid, "rsp valid right after reset")

endmodule

bind block_epistasis_xor_transform ebx_checker u_ebx_checker (.*);
